// File: src/uer_pkg.sv
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
`default_nettype none

package uer_pkg;

  localparam int unsigned SENSORS_DEF = 7;

  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned PULSE_W = 8;
  localparam int unsigned DIST_W  = 13;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [COUNT_W-1:0] TIMEOUT_RESET = 16'd1300;
  localparam logic [PULSE_W-1:0] TRIGGER_RESET = 8'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_TRIGGER = 1'b1;

  // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT, exact for y < 2**18
  localparam int unsigned        DIV_IN_W    = 18;
  localparam int unsigned        DIV25_W     = 19;
  localparam int unsigned        DIV25_SHIFT = 23;
  localparam logic [DIV25_W-1:0] DIV25_MUL   = 19'd335545;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_TRIG  = 4'b0010,
    PH_WAIT  = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] timeout_limit;
    logic [PULSE_W-1:0] trigger_ticks;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic timed_out;
  } status_t;

endpackage : uer_pkg

`default_nettype wire

// File: src/ultrasonic_echo_ranger.sv
// ultrasonic_echo_ranger: top level of the multi-channel ultrasonic ranger
// depends on uer_pkg, uer_cfg, uer_ctrl and uer_dist
//
// usage
//   - every input transfer is one timer tick: start request, channel number
//     and the sampled echo line levels; every tick yields exactly one output
//     transfer with trigger line levels, busy, done, distance and timed out
//   - a start from idle drives the chosen trigger line for trigger_ticks ticks,
//     then waits for that echo to rise and counts ticks while it stays high;
//     done pulses for one result with distance = count*170/2000
//   - pipeline: each result passes the input register, the control stage
//     and the distance/output register
//   - throughput: one transfer per cycle; the control state updates once per
//     accepted tick in a single stage, the distance uses one 18x19 multiply
//   - receiver stall: ready is combinational through all three stages; empty
//     stages keep taking ticks until all hold one, then in_ready = out_ready
//   - reset (synchronous, rst_n low): idle phase, counters cleared, pipeline
//     empty, timeout_limit = 1300, trigger_ticks = 2
//   - config: apb-style, timeout_limit at 0x0, trigger_ticks at 0x4;
//     write only while no ticks are in flight
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output      logic [APB_DW-1:0]  prdata,
  output      logic               pready,
  // tick input channel
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               in_start_req,
  input  wire logic [CHAN_W-1:0]  in_channel,
  input  wire logic [SENSORS-1:0] in_echo_lines,
  // result channel
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [SENSORS-1:0] out_trigger_lines,
  output      logic               out_busy_res,
  output      logic               out_done_res,
  output      logic [DIST_W-1:0]  out_distance,
  output      logic               out_timed_out
);

  cfg_t cfg;

  // input register stage
  logic               a_valid_r;
  logic               a_start_r;
  logic [CHAN_W-1:0]  a_channel_r;
  logic [SENSORS-1:0] a_echo_r;
  logic               a_ready;
  logic               in_take;

  // control stage to distance stage
  logic               b_valid;
  logic               b_ready;
  logic [SENSORS-1:0] b_trigger;
  status_t            b_status;
  logic [COUNT_W-1:0] b_count;

  status_t            out_status;

  uer_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input stage takes a tick whenever it is empty or draining this cycle
  assign in_ready = !a_valid_r || a_ready;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_start_r   <= in_start_req;
      a_channel_r <= in_channel;
      a_echo_r    <= in_echo_lines;
    end
  end

  // phase machine: idle -> trigger -> wait for echo -> counting -> idle
  uer_ctrl #(
    .SENSORS (SENSORS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .s_valid      (a_valid_r),
    .s_ready      (a_ready),
    .s_start_req  (a_start_r),
    .s_channel    (a_channel_r),
    .s_echo_lines (a_echo_r),
    .m_valid      (b_valid),
    .m_ready      (b_ready),
    .m_trigger    (b_trigger),
    .m_status     (b_status),
    .m_count      (b_count)
  );

  // distance conversion feeds the output register directly
  uer_dist #(
    .SENSORS (SENSORS)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_valid    (b_valid),
    .s_ready    (b_ready),
    .s_trigger  (b_trigger),
    .s_status   (b_status),
    .s_count    (b_count),
    .m_valid    (out_valid),
    .m_ready    (out_ready),
    .m_trigger  (out_trigger_lines),
    .m_status   (out_status),
    .m_distance (out_distance)
  );

  assign out_busy_res  = out_status.busy;
  assign out_done_res  = out_status.done;
  assign out_timed_out = out_status.timed_out;

endmodule : ultrasonic_echo_ranger

`default_nettype wire

// File: src/uer_cfg.sv
// uer_cfg: apb-style register file holding timeout limit and trigger width
// depends on uer_pkg
`default_nettype none

module uer_cfg
  import uer_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg
);

  logic [COUNT_W-1:0] timeout_limit_r;
  logic [PULSE_W-1:0] trigger_ticks_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_RESET;
      trigger_ticks_r <= TRIGGER_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TIMEOUT: timeout_limit_r <= pwdata[COUNT_W-1:0];
        REG_TRIGGER: trigger_ticks_r <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT: prdata = {{(APB_DW-COUNT_W){1'b0}}, timeout_limit_r};
      REG_TRIGGER: prdata = {{(APB_DW-PULSE_W){1'b0}}, trigger_ticks_r};
      default:     prdata = '0;
    endcase
  end

  assign cfg.timeout_limit = timeout_limit_r;
  assign cfg.trigger_ticks = trigger_ticks_r;

endmodule : uer_cfg

`default_nettype wire

// File: src/uer_ctrl.sv
// uer_ctrl: per-tick measurement state machine and control result stage
// depends on uer_pkg
`default_nettype none

module uer_ctrl
  import uer_pkg::*;
#(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               s_valid,
  output      logic               s_ready,
  input  wire logic               s_start_req,
  input  wire logic [CHAN_W-1:0]  s_channel,
  input  wire logic [SENSORS-1:0] s_echo_lines,
  output      logic               m_valid,
  input  wire logic               m_ready,
  output      logic [SENSORS-1:0] m_trigger,
  output      status_t            m_status,
  output      logic [COUNT_W-1:0] m_count
);

  localparam int unsigned SEL_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  phase_t             phase_r, phase_nxt;
  logic [SEL_W-1:0]   sensor_r, sensor_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;

  logic               valid_r;
  logic [SENSORS-1:0] trig_r, trig_nxt;
  status_t            status_r, status_nxt;
  logic [COUNT_W-1:0] dcount_r, dcount_nxt;

  logic               take;
  logic [PULSE_W-1:0] width;
  logic               echo;
  logic               chan_ok;
  logic               over;

  assign s_ready = !valid_r || m_ready;
  assign take    = s_valid && s_ready;

  assign width   = (cfg.trigger_ticks == '0) ? PULSE_W'(1) : cfg.trigger_ticks;
  assign echo    = s_echo_lines[sensor_r];
  assign chan_ok = ({1'b0, s_channel} < (CHAN_W+1)'(SENSORS));
  assign over    = count_r > cfg.timeout_limit;

  always_comb begin
    phase_nxt  = phase_r;
    sensor_nxt = sensor_r;
    count_nxt  = count_r;
    pulse_nxt  = pulse_r;
    trig_nxt   = '0;
    status_nxt = '0;
    dcount_nxt = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (s_start_req && chan_ok) begin
          sensor_nxt = s_channel[SEL_W-1:0];
          pulse_nxt  = PULSE_W'(1);
          count_nxt  = '0;
          phase_nxt  = PH_TRIG;
          trig_nxt   = SENSORS'(1) << s_channel[SEL_W-1:0];
        end
      end
      PH_TRIG: begin
        if (pulse_r >= width) begin
          pulse_nxt = '0;
          phase_nxt = PH_WAIT;
        end else begin
          pulse_nxt = pulse_r + PULSE_W'(1);
          trig_nxt  = SENSORS'(1) << sensor_r;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          count_nxt = '0;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (over || !echo) begin
          status_nxt.timed_out = over;
          status_nxt.done      = 1'b1;
          dcount_nxt           = count_r;
          count_nxt            = '0;
          phase_nxt            = PH_IDLE;
        end else if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
    status_nxt.busy = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sensor_r <= '0;
      count_r  <= '0;
      pulse_r  <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (take) begin
        phase_r  <= phase_nxt;
        sensor_r <= sensor_nxt;
        count_r  <= count_nxt;
        pulse_r  <= pulse_nxt;
      end
      if (s_ready) begin
        valid_r <= s_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      trig_r   <= trig_nxt;
      status_r <= status_nxt;
      dcount_r <= dcount_nxt;
    end
  end

  assign m_valid   = valid_r;
  assign m_trigger = trig_r;
  assign m_status  = status_r;
  assign m_count   = dcount_r;

endmodule : uer_ctrl

`default_nettype wire

// File: src/uer_dist.sv
// uer_dist: converts the echo count to distance and holds the output register
// depends on uer_pkg
`default_nettype none

module uer_dist
  import uer_pkg::*;
#(
  parameter int unsigned SENSORS = SENSORS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s_valid,
  output      logic               s_ready,
  input  wire logic [SENSORS-1:0] s_trigger,
  input  wire status_t            s_status,
  input  wire logic [COUNT_W-1:0] s_count,
  output      logic               m_valid,
  input  wire logic               m_ready,
  output      logic [SENSORS-1:0] m_trigger,
  output      status_t            m_status,
  output      logic [DIST_W-1:0]  m_distance
);

  localparam int unsigned X_W    = COUNT_W + 5;
  localparam int unsigned PROD_W = DIV_IN_W + DIV25_W;

  logic               valid_r;
  logic [SENSORS-1:0] trig_r;
  status_t            status_r;
  logic [DIST_W-1:0]  dist_r;

  logic [X_W-1:0]      x17;
  logic [DIV_IN_W-1:0] x_div8;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   dist_nxt;
  logic                take;

  // count*170/2000 = floor(floor(count*17/8)/25)
  assign x17      = (X_W'(s_count) << 4) + X_W'(s_count);
  assign x_div8   = x17[X_W-1:3];
  assign prod     = PROD_W'(x_div8) * PROD_W'(DIV25_MUL);
  assign dist_nxt = prod[DIV25_SHIFT +: DIST_W];

  assign s_ready = !valid_r || m_ready;
  assign take    = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      trig_r   <= s_trigger;
      status_r <= s_status;
      dist_r   <= dist_nxt;
    end
  end

  assign m_valid    = valid_r;
  assign m_trigger  = trig_r;
  assign m_status   = status_r;
  assign m_distance = dist_r;

endmodule : uer_dist

`default_nettype wire

// File: verif/tb.sv
// tb: self-checking testbench for ultrasonic_echo_ranger, one tick per input transfer
// depends on uer_pkg and the ultrasonic_echo_ranger rtl; needs no other files
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int unsigned SENSORS   = SENSORS_DEF;
  // distance = count * 5 * 34 / 2000
  localparam int unsigned SOUND_MUL = 5 * 34;
  localparam int unsigned DIST_DIV  = 2000;

  // one expected or observed output transfer
  typedef struct {
    logic [SENSORS-1:0] trigger;
    logic               busy;
    logic               done;
    logic [DIST_W-1:0]  distance;
    logic               timed_out;
  } tick_result_t;

  // tracks the ranger's state per accepted tick and checks every result
  class echo_range_tracker;
    logic [COUNT_W-1:0] timeout_limit;
    logic [PULSE_W-1:0] trigger_ticks;
    phase_t             phase;
    logic [CHAN_W-1:0]  sensor;
    logic [COUNT_W-1:0] echo_count;
    logic [PULSE_W-1:0] pulse_count;
    tick_result_t       expected_ticks[$];
    int                 errors;

    function new();
      timeout_limit = TIMEOUT_RESET;
      trigger_ticks = TRIGGER_RESET;
      phase         = PH_IDLE;
      sensor        = '0;
      echo_count    = '0;
      pulse_count   = '0;
      errors        = 0;
    endfunction

    function void write_register(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_TIMEOUT) timeout_limit = value[COUNT_W-1:0];
      else trigger_ticks = value[PULSE_W-1:0];
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void note_tick(logic start, logic [CHAN_W-1:0] chan, logic [SENSORS-1:0] echoes);
      tick_result_t       r;
      logic [PULSE_W-1:0] width;
      logic               echo;
      logic [31:0]        scaled;
      r = '{trigger: '0, busy: 1'b0, done: 1'b0, distance: '0, timed_out: 1'b0};
      width = (trigger_ticks == 0) ? 8'd1 : trigger_ticks;
      echo = echoes[sensor];
      case (phase)
        PH_IDLE: begin
          if (start && chan < SENSORS) begin
            sensor      = chan;
            pulse_count = 8'd1;
            echo_count  = '0;
            phase       = PH_TRIG;
            r.trigger   = SENSORS'(1) << chan;
          end
        end
        PH_TRIG: begin
          if (pulse_count >= width) begin
            pulse_count = '0;
            phase       = PH_WAIT;
          end else begin
            pulse_count = pulse_count + 8'd1;
            r.trigger   = SENSORS'(1) << sensor;
          end
        end
        PH_WAIT: begin
          if (echo) begin
            echo_count = '0;
            phase      = PH_COUNT;
          end
        end
        default: begin
          // limit check wins over a falling echo; distance from the count held so far
          if (echo_count > timeout_limit || !echo) begin
            r.timed_out = echo_count > timeout_limit;
            r.done      = 1'b1;
            scaled      = 32'(echo_count) * SOUND_MUL / DIST_DIV;
            r.distance  = scaled[DIST_W-1:0];
            echo_count  = '0;
            phase       = PH_IDLE;
          end else if (echo_count != COUNT_MAX) begin
            echo_count = echo_count + 16'd1;
          end
        end
      endcase
      r.busy = (phase != PH_IDLE);
      expected_ticks.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        $display("%0t ns: result transfer with none expected, trigger %0h done %0b",
                 $time, got.trigger, got.done);
        errors++;
        return;
      end
      want = expected_ticks.pop_front();
      compare_field("trigger_lines", 16'(want.trigger), 16'(got.trigger));
      compare_field("busy_res", 16'(want.busy), 16'(got.busy));
      compare_field("done_res", 16'(want.done), 16'(got.done));
      compare_field("distance", 16'(want.distance), 16'(got.distance));
      compare_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               in_start_req;
  logic [CHAN_W-1:0]  in_channel;
  logic [SENSORS-1:0] in_echo_lines;
  logic               out_valid;
  logic               out_ready;
  logic [SENSORS-1:0] out_trigger_lines;
  logic               out_busy_res;
  logic               out_done_res;
  logic [DIST_W-1:0]  out_distance;
  logic               out_timed_out;

  echo_range_tracker tracker = new();
  bit                idle_on = 1'b1;  // random gaps on both channels when set
  int                ticks_sent = 0;

  ultrasonic_echo_ranger #(
    .SENSORS(SENSORS)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_start_req      (in_start_req),
    .in_channel        (in_channel),
    .in_echo_lines     (in_echo_lines),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_lines (out_trigger_lines),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_distance      (out_distance),
    .out_timed_out     (out_timed_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // every output transfer is checked against the oldest expected tick
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      tracker.check_tick('{out_trigger_lines, out_busy_res, out_done_res,
                           out_distance, out_timed_out});
  end

  // receiver: random stall before each transfer while idle_on is set
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  // one tick; returns right after the accepting edge so valid can stay high
  task automatic send_tick(logic start, logic [CHAN_W-1:0] chan, logic [SENSORS-1:0] echoes);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_channel    <= chan;
    in_echo_lines <= echoes;
    do @(posedge clk); while (!in_ready);
    tracker.note_tick(start, chan, echoes);
    ticks_sent++;
  endtask

  function automatic logic [SENSORS-1:0] set_echo(logic [SENSORS-1:0] base,
                                                  logic [CHAN_W-1:0] idx, logic level);
    base[idx] = level;
    return base;
  endfunction

  // starts are ignored while busy, so random starts are safe here
  task automatic busy_tick(logic level);
    send_tick(1'($urandom), 3'($urandom),
              set_echo(7'($urandom), tracker.sensor, level));
  endtask

  // run the block back to idle: raise the echo if waiting, drop it if counting
  task automatic settle_idle();
    while (tracker.phase != PH_IDLE) busy_tick(tracker.phase != PH_COUNT);
  endtask

  // start, trigger pulse, echo low for wait_ticks, high for high_ticks, then low
  task automatic measure(logic [CHAN_W-1:0] chan, int wait_ticks, int high_ticks);
    int i;
    send_tick(1'b1, chan, 7'($urandom));
    while (tracker.phase == PH_TRIG) busy_tick(1'($urandom));
    for (i = 0; i < wait_ticks; i++) busy_tick(1'b0);
    for (i = 0; i < high_ticks && tracker.phase != PH_IDLE; i++) busy_tick(1'b1);
    settle_idle();
  endtask

  // single noise tick, bad channel included
  task automatic noise_tick();
    send_tick(1'($urandom), 3'($urandom), 7'($urandom));
  endtask

  // block idle and every result back before anything else happens
  task automatic quiesce();
    settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic cfg_write(logic idx, logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int c;
    int k;
    int phase_end;
    int high_cap;
    logic [COUNT_W-1:0] tmo;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_start_req  = 1'b0;
    in_channel    = '0;
    in_echo_lines = '0;
    rst_n         = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, every channel, zero count, bad channel, no start
    measure(3'd0, 0, 0);
    measure(3'd6, 3, 12);
    send_tick(1'b1, 3'd7, 7'h7F);
    send_tick(1'b0, 3'd3, 7'h7F);
    send_tick(1'b0, 3'd0, 7'h00);
    for (c = 1; c < 6; c++) measure(3'(c), 1, c * 3);
    quiesce();

    // zero limit times out after one count; zero trigger width acts as one
    cfg_write(REG_TIMEOUT, 32'd0);
    cfg_write(REG_TRIGGER, 32'd0);
    measure(3'd2, 1, 5);
    quiesce();
    cfg_write(REG_TRIGGER, 32'd1);
    measure(3'd3, 0, 2);
    quiesce();
    cfg_write(REG_TRIGGER, 32'd255);
    cfg_write(REG_TIMEOUT, 32'd1300);
    measure(3'd1, 2, 3);
    quiesce();

    // top limit without gaps: counting stays far below the limit
    idle_on = 1'b0;
    cfg_write(REG_TRIGGER, 32'd1);
    cfg_write(REG_TIMEOUT, 32'd65534);
    measure(3'd3, 2, 100);
    quiesce();
    idle_on = 1'b1;

    // random phases, each with its own settings; one of them without gaps
    for (k = 0; k < 4; k++) begin
      tmo = (k == 1) ? 16'd1300 : 16'($urandom_range(0, 40));
      cfg_write(REG_TIMEOUT, {16'($urandom), tmo});
      cfg_write(REG_TRIGGER, {24'($urandom), 8'($urandom_range(0, 6))});
      idle_on  = (k != 2);
      high_cap = (tmo + 4 > 60) ? 60 : tmo + 4;
      phase_end = ticks_sent + 350;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(0, 9) < 8)
          measure(3'($urandom_range(0, 6)), $urandom_range(0, 4),
                  $urandom_range(0, high_cap));
        else
          repeat ($urandom_range(1, 4)) noise_tick();
      end
      quiesce();
    end
    idle_on = 1'b1;

    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
